FILE: src/single_wire_bus_command_receiver_top_macros.svh
// assertion macros for the single-wire bus command receiver checker
// no dependencies; taken in by the checker file
`ifndef SINGLE_WIRE_BUS_COMMAND_RECEIVER_TOP_MACROS_SVH
`define SINGLE_WIRE_BUS_COMMAND_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SWBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swbr check failed");

// next-cycle implication, disabled while reset is low
`define SWBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swbr check failed");

`endif

FILE: src/swbr_pkg.sv
// shared types, phase and event codes for the single-wire bus command receiver
// no dependencies
`timescale 1ns / 1ps

package swbr_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int CFG_ADDR_W = 4;

    // decoder phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SYNC  = 3'd1;
    localparam logic [2:0] PH_BITS  = 3'd2;
    localparam logic [2:0] PH_STOP  = 3'd3;
    localparam logic [2:0] PH_TURN  = 3'd4;
    localparam logic [2:0] PH_START = 3'd5;

    // event kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_RESET   = 2'd1;
    localparam logic [1:0] KIND_COMMAND = 2'd2;
    localparam logic [1:0] KIND_LISTEN  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_RESET_PULSE_MIN = 2'd0;
    localparam logic [1:0] REG_ATTENTION_MIN   = 2'd1;
    localparam logic [1:0] REG_HALF_CELL_MIN   = 2'd2;
    localparam logic [1:0] REG_LISTEN_GAP_MIN  = 2'd3;

    // register reset values
    localparam logic [15:0] RESET_PULSE_MIN_DEF = 16'd4500;
    localparam logic [15:0] ATTENTION_MIN_DEF   = 16'd1200;
    localparam logic [15:0] HALF_CELL_MIN_DEF   = 16'd90;
    localparam logic [15:0] LISTEN_GAP_MIN_DEF  = 16'd300;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] LISTEN_BYTES  = 2'd2;
    localparam logic [1:0] LISTEN_REG_CODE = 2'd2;

    typedef struct packed {
        logic [15:0] reset_pulse_min;
        logic [15:0] attention_min;
        logic [15:0] half_cell_min;
        logic [15:0] listen_gap_min;
    } swbr_cfg_t;

    typedef struct packed {
        logic        line_level;
        logic [31:0] edge_time;
        logic        device_listening;
        logic        listen_accepted;
    } swbr_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] last_edge_tick;
        logic [7:0]  shift_byte;
        logic [3:0]  bit_count;
        logic [1:0]  listen_count;
    } swbr_state_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] data_byte;
        logic       device_reset;
        logic       listen_opened;
        logic       listen_closed;
    } swbr_result_t;

endpackage

FILE: src/swbr_decode.sv
// per-edge phase decoder: next state and result word from one edge
// depends on swbr_pkg
`timescale 1ns / 1ps

module swbr_decode
    import swbr_pkg::*;
(
    input  swbr_cfg_t    cfg,
    input  swbr_state_t  st,
    input  swbr_item_t   item,
    output swbr_state_t  st_next,
    output swbr_result_t res
);

    logic [31:0] duration;
    logic        long_half;
    logic [3:0]  bit_count_inc;
    logic [1:0]  listen_count_inc;

    assign duration         = item.edge_time - st.last_edge_tick;
    assign long_half        = duration >= {16'd0, cfg.half_cell_min};
    assign bit_count_inc    = st.bit_count + 4'd1;
    assign listen_count_inc = st.listen_count + 2'd1;

    always_comb begin
        st_next                = st;
        st_next.last_edge_tick = item.edge_time;
        res                    = '0;
        case (st.phase)
            PH_SYNC: begin
                if (!item.line_level && long_half) begin
                    st_next.phase      = PH_BITS;
                    st_next.shift_byte = '0;
                    st_next.bit_count  = '0;
                end
            end
            PH_BITS: begin
                if (!item.line_level) begin
                    st_next.shift_byte = {st.shift_byte[6:0], long_half};
                    st_next.bit_count  = bit_count_inc;
                    if (bit_count_inc == BITS_PER_BYTE) begin
                        st_next.phase = PH_STOP;
                    end
                end
            end
            PH_STOP: begin
                if (item.line_level) begin
                    res.data_byte = st.shift_byte;
                    if (st.listen_count != 2'd0 || item.device_listening) begin
                        res.event_kind = KIND_LISTEN;
                        if (listen_count_inc < LISTEN_BYTES) begin
                            st_next.listen_count = listen_count_inc;
                            st_next.phase        = PH_BITS;
                            st_next.shift_byte   = '0;
                            st_next.bit_count    = '0;
                        end else begin
                            st_next.listen_count = '0;
                            st_next.phase        = PH_IDLE;
                            res.listen_closed    = 1'b1;
                        end
                    end else begin
                        res.event_kind = KIND_COMMAND;
                        st_next.phase  = PH_IDLE;
                        if (st.shift_byte == 8'd0) begin
                            res.device_reset = 1'b1;
                        end else if (st.shift_byte[3:2] == LISTEN_REG_CODE &&
                                     item.listen_accepted) begin
                            st_next.listen_count = '0;
                            st_next.phase        = PH_TURN;
                            res.listen_opened    = 1'b1;
                        end
                    end
                end
            end
            PH_TURN: begin
                if (!item.line_level && duration >= {16'd0, cfg.listen_gap_min}) begin
                    st_next.phase = PH_START;
                end
            end
            PH_START: begin
                if (!item.line_level && long_half) begin
                    st_next.phase      = PH_BITS;
                    st_next.shift_byte = '0;
                    st_next.bit_count  = '0;
                end
            end
            default: begin
                // idle, and the two unused codes behave as idle
                st_next.phase = PH_IDLE;
                if (item.line_level) begin
                    if (duration >= {16'd0, cfg.reset_pulse_min}) begin
                        res.event_kind   = KIND_RESET;
                        res.device_reset = 1'b1;
                    end else if (duration >= {16'd0, cfg.attention_min}) begin
                        st_next.phase      = PH_SYNC;
                        st_next.shift_byte = '0;
                        st_next.bit_count  = '0;
                    end
                end
            end
        endcase
    end

endmodule

FILE: src/single_wire_bus_command_receiver_top.sv
// top level of the single-wire bus command receiver: stream ports, register port
// depends on swbr_pkg and swbr_decode
`timescale 1ns / 1ps

// Host-edge decoder for an open-collector single-wire desktop bus. Each input
// word is one host line edge (new level plus a 32-bit tick timestamp) and every
// edge yields exactly one result word: none, bus reset, command byte or listen
// data byte, with device reset, listen opened and listen closed flags. Time
// between edges is taken modulo 2^32. An edge passes an input register, then
// one pass of the phase decoder that updates the bus state and loads the
// result register, so a word is taken every clock cycle while the result side
// does not stall; a stall on the result side holds the input register until
// the result register frees. The four 16-bit threshold registers sit at
// byte addresses 0, 4, 8 and 12 and are meant to be written while no edge is
// in flight.
module single_wire_bus_command_receiver_top
    import swbr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] line_level, [32:1] edge_time, [33] device_listening,
    // [34] listen_accepted, [39:35] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] data_byte, [8] device_reset, [9] listen_opened,
    // [10] listen_closed, [15:11] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [1:0] event_kind
    output logic [1:0]            m_tuser,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // configuration registers
    swbr_cfg_t    cfg_reg;
    logic         cfg_wr;
    logic [1:0]   cfg_idx;

    // input stage
    logic         in_valid_reg;
    swbr_item_t   item_reg;

    // bus state and result stage
    swbr_state_t  st_reg;
    swbr_state_t  st_next;
    swbr_result_t res_next;
    swbr_result_t res_reg;
    logic         out_valid_reg;

    logic         advance;

    // register port: no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_pulse_min <= RESET_PULSE_MIN_DEF;
            cfg_reg.attention_min   <= ATTENTION_MIN_DEF;
            cfg_reg.half_cell_min   <= HALF_CELL_MIN_DEF;
            cfg_reg.listen_gap_min  <= LISTEN_GAP_MIN_DEF;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RESET_PULSE_MIN: cfg_reg.reset_pulse_min <= pwdata[15:0];
                REG_ATTENTION_MIN:   cfg_reg.attention_min   <= pwdata[15:0];
                REG_HALF_CELL_MIN:   cfg_reg.half_cell_min   <= pwdata[15:0];
                REG_LISTEN_GAP_MIN:  cfg_reg.listen_gap_min  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        case (cfg_idx)
            REG_RESET_PULSE_MIN: prdata = {16'd0, cfg_reg.reset_pulse_min};
            REG_ATTENTION_MIN:   prdata = {16'd0, cfg_reg.attention_min};
            REG_HALF_CELL_MIN:   prdata = {16'd0, cfg_reg.half_cell_min};
            REG_LISTEN_GAP_MIN:  prdata = {16'd0, cfg_reg.listen_gap_min};
            default:             prdata = '0;
        endcase
    end

    // the held word moves on when the result register is empty or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.line_level       <= s_tdata[0];
            item_reg.edge_time        <= s_tdata[32:1];
            item_reg.device_listening <= s_tdata[33];
            item_reg.listen_accepted  <= s_tdata[34];
        end
    end

    swbr_decode u_decode (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // bus state advances once per decoded edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase          <= PH_IDLE;
            st_reg.last_edge_tick <= '0;
            st_reg.shift_byte     <= '0;
            st_reg.bit_count      <= '0;
            st_reg.listen_count   <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.event_kind;
    assign m_tdata  = {5'd0, res_reg.listen_closed, res_reg.listen_opened,
                       res_reg.device_reset, res_reg.data_byte};

endmodule

FILE: src/swbr_checker.sv
// port-level checks for the single-wire bus command receiver, with its bind
// depends on swbr_pkg and single_wire_bus_command_receiver_top_macros.svh
`timescale 1ns / 1ps
`include "single_wire_bus_command_receiver_top_macros.svh"

module swbr_checker
    import swbr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // a stalled result word holds
    `SWBR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // listen opens only on a command byte
    `SWBR_ASSERT_NOW(a_open_on_cmd, aclk, aresetn, m_tvalid && m_tdata[9], m_tuser == KIND_COMMAND)

    // listen closes only on a listen byte
    `SWBR_ASSERT_NOW(a_close_on_listen, aclk, aresetn, m_tvalid && m_tdata[10], m_tuser == KIND_LISTEN)

    // device reset comes from a long pulse or command zero
    `SWBR_ASSERT_NOW(a_reset_src, aclk, aresetn, m_tvalid && m_tdata[8], m_tuser == KIND_RESET || (m_tuser == KIND_COMMAND && m_tdata[7:0] == 8'd0))

    // no byte rides on a word without data
    `SWBR_ASSERT_NOW(a_no_byte, aclk, aresetn, m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_RESET), m_tdata[7:0] == 8'd0)

endmodule

bind single_wire_bus_command_receiver_top swbr_checker u_swbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: verif/testbench.sv
// self-checking testbench for the single-wire bus command receiver
// depends on swbr_pkg and single_wire_bus_command_receiver_top
`timescale 1ns / 1ps

module testbench;
    import swbr_pkg::*;

    // generous bound: every word stalled by the receiver and gapped by the sender
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // [0] line_level, [32:1] edge_time, [33] device_listening,
    // [34] listen_accepted, [39:35] zero
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // [7:0] data_byte, [8] device_reset, [9] listen_opened,
    // [10] listen_closed, [15:11] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    // [1:0] event_kind
    logic [1:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    single_wire_bus_command_receiver_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // decoder mirror: bus state and thresholds as the block should hold them
    swbr_state_t  bus_mirror;
    swbr_cfg_t    thresholds;
    swbr_result_t pending_events[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned edges_sent = 0;
    logic [31:0] tick_now = 32'd0;

    // traffic shaping knobs, changed per test
    bit          bursty = 1'b1;
    bit          stall_on = 1'b1;
    bit          mangle_on = 1'b0;
    int unsigned burst_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned pattern_age = 0;

    // ------------------------------------------------------------------
    // decoder mirror
    // ------------------------------------------------------------------

    function automatic void open_byte();
        bus_mirror.phase = PH_BITS;
        bus_mirror.shift_byte = 8'd0;
        bus_mirror.bit_count = 4'd0;
    endfunction

    // one edge in, one result word out; updates the mirrored bus state
    task automatic decode_edge(input swbr_item_t it, output swbr_result_t ev);
        logic [31:0] span;
        span = it.edge_time - bus_mirror.last_edge_tick;
        bus_mirror.last_edge_tick = it.edge_time;
        ev = '0;
        case (bus_mirror.phase)
            PH_SYNC: begin
                if (!it.line_level && span >= thresholds.half_cell_min) open_byte();
            end
            PH_BITS: begin
                // falling edge closes a high time: wide high is a one
                if (!it.line_level) begin
                    bus_mirror.shift_byte = {bus_mirror.shift_byte[6:0],
                                             span >= thresholds.half_cell_min};
                    bus_mirror.bit_count = bus_mirror.bit_count + 4'd1;
                    if (bus_mirror.bit_count == BITS_PER_BYTE) bus_mirror.phase = PH_STOP;
                end
            end
            PH_STOP: begin
                if (it.line_level) begin
                    ev.data_byte = bus_mirror.shift_byte;
                    if (bus_mirror.listen_count != 2'd0 || it.device_listening) begin
                        // byte goes to the listening device
                        ev.event_kind = KIND_LISTEN;
                        bus_mirror.listen_count = bus_mirror.listen_count + 2'd1;
                        if (bus_mirror.listen_count < LISTEN_BYTES) begin
                            open_byte();
                        end else begin
                            bus_mirror.listen_count = 2'd0;
                            bus_mirror.phase = PH_IDLE;
                            ev.listen_closed = 1'b1;
                        end
                    end else begin
                        ev.event_kind = KIND_COMMAND;
                        bus_mirror.phase = PH_IDLE;
                        if (bus_mirror.shift_byte == 8'd0) begin
                            ev.device_reset = 1'b1;
                        end else if (bus_mirror.shift_byte[3:2] == LISTEN_REG_CODE &&
                                     it.listen_accepted) begin
                            bus_mirror.listen_count = 2'd0;
                            bus_mirror.phase = PH_TURN;
                            ev.listen_opened = 1'b1;
                        end
                    end
                end
            end
            PH_TURN: begin
                if (!it.line_level && span >= thresholds.listen_gap_min)
                    bus_mirror.phase = PH_START;
            end
            PH_START: begin
                if (!it.line_level && span >= thresholds.half_cell_min) open_byte();
            end
            default: begin
                // idle, and the two unused codes fall back to idle
                bus_mirror.phase = PH_IDLE;
                if (it.line_level) begin
                    if (span >= thresholds.reset_pulse_min) begin
                        ev.event_kind = KIND_RESET;
                        ev.device_reset = 1'b1;
                    end else if (span >= thresholds.attention_min) begin
                        bus_mirror.phase = PH_SYNC;
                        bus_mirror.shift_byte = 8'd0;
                        bus_mirror.bit_count = 4'd0;
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    // write one threshold, then read it back over the same port
    task automatic write_threshold(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_RESET_PULSE_MIN: thresholds.reset_pulse_min = value;
            REG_ATTENTION_MIN:   thresholds.attention_min = value;
            REG_HALF_CELL_MIN:   thresholds.half_cell_min = value;
            default:             thresholds.listen_gap_min = value;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // access cycle of the read: data is sampled at this edge
        if (prdata[15:0] !== value) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, value, prdata[15:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // psel and penable drop between transfers
        @(posedge aclk);
    endtask

    task automatic load_thresholds(input logic [15:0] rst_min, input logic [15:0] att_min,
                                   input logic [15:0] half_min, input logic [15:0] gap_min);
        write_threshold(REG_RESET_PULSE_MIN, rst_min);
        write_threshold(REG_ATTENTION_MIN, att_min);
        write_threshold(REG_HALF_CELL_MIN, half_min);
        write_threshold(REG_LISTEN_GAP_MIN, gap_min);
    endtask

    // ------------------------------------------------------------------
    // edge stream
    // ------------------------------------------------------------------

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // duration at or above a threshold, or below it, often right at the boundary
    function automatic logic [31:0] pick_len(input logic [15:0] limit, input bit above);
        if (above || limit == 16'd0)
            return {16'd0, limit} + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
        return ($urandom_range(0, 1) == 0) ? {16'd0, limit} - 32'd1
                                           : 32'($urandom_range(0, limit - 16'd1));
    endfunction

    // low pulse that lands on attention, or now and then on either side of it
    function automatic logic [31:0] attention_len();
        int unsigned span;
        if (thresholds.attention_min >= thresholds.reset_pulse_min || $urandom_range(0, 9) == 0)
            return pick_len(thresholds.attention_min, rand_bit());
        span = thresholds.reset_pulse_min - thresholds.attention_min - 1;
        return thresholds.attention_min + $urandom_range(0, span);
    endfunction

    // hand one edge word over, mirror it, then maybe leave a gap
    task automatic send_edge(input swbr_item_t it);
        swbr_result_t ev;
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it.listen_accepted, it.device_listening, it.edge_time, it.line_level};
        do @(posedge aclk); while (!s_tready);
        decode_edge(it, ev);
        pending_events.insert(pending_events.size(), ev);
        edges_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = bursty ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic edge_at(input logic level, input logic [31:0] stamp,
                           input logic listening, input logic accepted);
        swbr_item_t it;
        tick_now = stamp;
        it.line_level = level;
        it.edge_time = stamp;
        it.device_listening = listening;
        it.listen_accepted = accepted;
        send_edge(it);
    endtask

    // edge after a given duration; with mangling on, a few edges get corrupted
    task automatic drive_edge(input logic level, input logic [31:0] len,
                              input logic listening, input logic accepted);
        logic        lvl;
        logic [31:0] dur;
        lvl = level;
        dur = len;
        if (mangle_on && $urandom_range(0, 29) == 0) begin
            if (rand_bit()) lvl = !lvl;
            else dur = $urandom;
        end
        edge_at(lvl, tick_now + dur, listening, accepted);
    endtask

    // eight bit cells: falling edge ends the high time, rising edge ends the low;
    // the last rising edge is the stop edge that reports the byte
    task automatic send_bits(input logic [7:0] value, input logic listening,
                             input logic accepted);
        for (int i = 7; i >= 0; i--) begin
            drive_edge(1'b0, pick_len(thresholds.half_cell_min, value[i]),
                       rand_bit(), rand_bit());
            drive_edge(1'b1, $urandom_range(1, 120),
                       (i == 0) ? listening : rand_bit(),
                       (i == 0) ? accepted : rand_bit());
        end
    endtask

    // attention, sync, command byte and, for an accepted listen, two data bytes
    task automatic send_frame();
        logic [7:0] cmd;
        logic       listening;
        logic       accepted;
        int unsigned pick;
        pick = $urandom_range(0, 7);
        cmd = 8'($urandom);
        if (pick == 0) cmd = 8'd0;
        else if (pick < 4) cmd[3:2] = LISTEN_REG_CODE;
        listening = ($urandom_range(0, 4) == 0);
        accepted = rand_bit();
        drive_edge(1'b0, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 500),
                   rand_bit(), rand_bit());
        drive_edge(1'b1, attention_len(), rand_bit(), rand_bit());
        drive_edge(1'b0, pick_len(thresholds.half_cell_min, $urandom_range(0, 9) != 0),
                   rand_bit(), rand_bit());
        drive_edge(1'b1, $urandom_range(1, 120), rand_bit(), rand_bit());
        send_bits(cmd, listening, accepted);
        if (!listening && cmd != 8'd0 && cmd[3:2] == LISTEN_REG_CODE && accepted) begin
            // turnaround, start bit, then the listen data
            drive_edge(1'b0, pick_len(thresholds.listen_gap_min, $urandom_range(0, 5) != 0),
                       rand_bit(), rand_bit());
            drive_edge(1'b1, $urandom_range(1, 120), rand_bit(), rand_bit());
            drive_edge(1'b0, pick_len(thresholds.half_cell_min, 1'b1), rand_bit(), rand_bit());
            drive_edge(1'b1, $urandom_range(1, 120), rand_bit(), rand_bit());
            send_bits(8'($urandom), $urandom_range(0, 7) != 0, rand_bit());
            send_bits(8'($urandom), rand_bit(), rand_bit());
        end
    endtask

    // unstructured edges: any level, short, threshold-sized or wrapping durations
    task automatic send_noise(input int unsigned count);
        logic [31:0] len;
        repeat (count) begin
            case ($urandom_range(0, 2))
                0:       len = $urandom;
                1:       len = $urandom_range(0, 200);
                default: len = pick_len(16'($urandom_range(0, 5000)), rand_bit());
            endcase
            drive_edge(rand_bit(), len, rand_bit(), rand_bit());
        end
    endtask

    task automatic run_traffic(input int unsigned budget);
        int unsigned goal;
        goal = edges_sent + budget;
        while (edges_sent < goal) begin
            if ($urandom_range(0, 5) == 0) begin
                send_noise($urandom_range(1, 4));
            end else begin
                mangle_on = ($urandom_range(0, 4) == 0);
                send_frame();
                mangle_on = 1'b0;
            end
        end
    endtask

    // drop valid and let every result drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // idle-phase corner cases under reset thresholds
    task automatic test_idle_special_cases();
        bursty = 1'b1;
        stall_on = 1'b1;
        // repeated low level, then a pulse meeting both reset and attention
        edge_at(1'b0, 32'd0, 1'b0, 1'b0);
        edge_at(1'b0, 32'd100, 1'b0, 1'b0);
        edge_at(1'b1, 32'd4600, 1'b0, 1'b0);
        // pulse one tick short of attention is dropped
        edge_at(1'b0, 32'd4700, 1'b0, 1'b0);
        edge_at(1'b1, 32'd5899, 1'b0, 1'b0);
        // timestamp going backward reads as a huge pulse
        edge_at(1'b0, 32'd6000, 1'b1, 1'b1);
        edge_at(1'b1, 32'd5000, 1'b1, 1'b1);
        // wrap across the top of the tick counter, short pulse
        edge_at(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        edge_at(1'b1, 32'h0000_0101, 1'b0, 1'b1);
        settle();
    endtask

    // attention just under reset, sync and bit cells at the boundary, command zero
    task automatic test_command_zero();
        drive_edge(1'b0, 32'd20, 1'b0, 1'b0);
        drive_edge(1'b1, 32'd4499, 1'b0, 1'b0);
        drive_edge(1'b1, 32'd30, 1'b0, 1'b0);
        drive_edge(1'b0, 32'd89, 1'b0, 1'b0);
        drive_edge(1'b0, 32'd90, 1'b0, 1'b0);
        repeat (8) drive_edge(1'b0, 32'd89, 1'b0, 1'b0);
        drive_edge(1'b1, 32'd40, 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_default_traffic();
        bursty = 1'b1;
        stall_on = 1'b1;
        run_traffic(110);
        settle();
    endtask

    // every threshold at zero: each rising edge in idle is a bus reset
    task automatic test_zero_thresholds();
        load_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        bursty = 1'b0;
        stall_on = 1'b0;
        run_traffic(90);
        settle();
    endtask

    task automatic test_max_thresholds();
        load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        bursty = 1'b1;
        stall_on = 1'b0;
        run_traffic(50);
        settle();
        // attention just below the largest reset pulse
        load_thresholds(16'hFFFF, 16'hFFF0, 16'hFFFF, 16'hFFFF);
        stall_on = 1'b1;
        run_traffic(50);
        settle();
    endtask

    task automatic test_random_thresholds();
        logic [15:0] att_min;
        repeat (2) begin
            att_min = 16'($urandom_range(0, 3000));
            load_thresholds(att_min + 16'($urandom_range(1, 3000)), att_min,
                            16'($urandom_range(0, 200)), 16'($urandom_range(0, 800)));
            bursty = rand_bit();
            stall_on = rand_bit();
            run_traffic(75);
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern, checker, watchdog
    // ------------------------------------------------------------------

    // receiver stall pattern, rotated every cycle and redrawn now and then
    always @(posedge aclk) begin
        if (pattern_age == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            pattern_age = 32;
        end
        pattern_age--;
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        m_tready <= !stall_on || ready_pattern[0];
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // each accepted result word against the oldest expected event
    always @(posedge aclk) begin
        swbr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("result word with no event expected");
                error_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", want.event_kind, m_tuser);
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("device_reset", want.device_reset, m_tdata[8]);
                check_field("listen_opened", want.listen_opened, m_tdata[9]);
                check_field("listen_closed", want.listen_closed, m_tdata[10]);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        bus_mirror = '0;
        thresholds.reset_pulse_min = RESET_PULSE_MIN_DEF;
        thresholds.attention_min   = ATTENTION_MIN_DEF;
        thresholds.half_cell_min   = HALF_CELL_MIN_DEF;
        thresholds.listen_gap_min  = LISTEN_GAP_MIN_DEF;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_special_cases();
        test_command_zero();
        test_default_traffic();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_thresholds();

        // drain, then wait for any stray word
        settle();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
